// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the execute block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, checked during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Property sampled on the rising clock edge, ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hw/rtl/cie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cie_pkg
// Opcodes, constants and the decoded instruction record of the execute block.
// ----------------------------------------------------------------------------
package cie_pkg;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_ADDI = 5'd1,
      OP_OR   = 5'd2,
      OP_AND  = 5'd3,
      OP_XOR  = 5'd4,
      OP_NOR  = 5'd5,
      OP_SLL  = 5'd6,
      OP_ROT  = 5'd7,
      OP_BNE  = 5'd8,
      OP_LDL  = 5'd9,
      OP_LDH  = 5'd10,
      OP_STL  = 5'd11,
      OP_STH  = 5'd12,
      OP_JMP  = 5'd13,
      OP_JAL  = 5'd14,
      OP_JR   = 5'd15,
      OP_JALR = 5'd16,
      OP_NOP  = 5'd17
   } op_type;

   localparam logic [31:0] STL_MASK = 32'h0000_00FF;
   localparam logic [15:0] PC_STEP  = 16'd2;

   // one instruction as it moves from the front end to the back end
   typedef struct packed {
      logic [4:0]         cmd;
      logic [2:0]         src_a;
      logic [2:0]         src_b;
      logic [2:0]         dest;
      logic signed [15:0] immediate;
      logic [15:0]        address;
      logic [15:0]        mem_idx;   // address reduced modulo the memory depth
   } item_type;

endpackage
`default_nettype wire

// ===== hw/rtl/cie_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cie_req_if
// Instruction channel: valid/ready handshake with the decoded fields.
// ----------------------------------------------------------------------------
interface cie_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         cmd;
   logic [2:0]         src_a;
   logic [2:0]         src_b;
   logic [2:0]         dest;
   logic signed [15:0] immediate;
   logic [15:0]        address;

   modport source (output valid, cmd, src_a, src_b, dest, immediate, address,
                   input ready);
   modport sink (input valid, cmd, src_a, src_b, dest, immediate, address,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cie_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cie_rsp_if
// Result channel: valid/ready handshake with value and next program counter.
// ----------------------------------------------------------------------------
interface cie_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [15:0] next_pc;

   modport source (output valid, value, next_pc, input ready);
   modport sink (input valid, value, next_pc, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cpu_instruction_execute.sv =====
// Path: a result is registered through the 2 address-reduction stages,
//   the queue, the execute stage and the result register.
// Throughput: one instruction per cycle unless stalled; the execute stage
//   retires one beat per cycle with register and memory operand bypass.
// Reset: synchronous; afterwards the data memory is swept to zero word by
//   word while req_chan.ready stays low.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_instruction_execute
// Single-issue instruction execute block: front end, queue, back end.
// ----------------------------------------------------------------------------
module cpu_instruction_execute #(
   parameter int NUM_REGS  = 8,
   parameter int MEM_WORDS = 1024
) (
   input  logic      clock,
   input  logic      reset,
   cie_req_if.sink   req_chan,
   cie_rsp_if.source rsp_chan
);

   logic              clearing;
   logic              push_valid, push_ready;
   cie_pkg::item_type push_item;
   logic              pop_valid, pop_ready;
   cie_pkg::item_type pop_item;

   cie_front #(
      .MEM_WORDS(MEM_WORDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_en (!clearing),
      .req_chan  (req_chan),
      .push_valid(push_valid),
      .push_item (push_item),
      .push_ready(push_ready)
   );

   cie_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_item (push_item),
      .push_ready(push_ready),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready)
   );

   cie_back #(
      .NUM_REGS (NUM_REGS),
      .MEM_WORDS(MEM_WORDS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_item (pop_item),
      .pop_ready(pop_ready),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/cie_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cie_front
// Accepts instruction beats and reduces the memory address modulo the
// memory depth in two registered steps (reciprocal multiply, back-multiply).
// ----------------------------------------------------------------------------
module cie_front #(
   parameter int MEM_WORDS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept_en,
   cie_req_if.sink           req_chan,
   output logic              push_valid,
   output cie_pkg::item_type push_item,
   input  logic              push_ready
);

   localparam longint unsigned RECIP_WIDE = (64'd1 << 32) / MEM_WORDS;
   localparam logic [31:0]     RECIP      = 32'(RECIP_WIDE);
   localparam logic [16:0]     WORDS      = 17'(MEM_WORDS);

   logic              s1_valid_ff, s1_valid_in;
   cie_pkg::item_type s1_item_ff, s1_item_in;
   logic [15:0]       s1_quot_ff, s1_quot_in;
   logic              s2_valid_ff, s2_valid_in;
   cie_pkg::item_type s2_item_ff;
   logic [15:0]       s2_prod_ff, s2_prod_in;

   logic        s1_take, s2_take, accept;
   logic [47:0] recip_prod;
   logic [31:0] back_prod;
   logic [16:0] rem_raw, rem_fix;

   assign s2_take        = !s2_valid_ff || push_ready;
   assign s1_take        = !s1_valid_ff || s2_take;
   assign req_chan.ready = accept_en && s1_take;
   assign accept         = req_chan.valid && req_chan.ready;

   // quotient estimate is q or q-1, so one correction step suffices
   assign recip_prod = 48'(req_chan.address) * 48'(RECIP);
   assign s1_quot_in = recip_prod[47:32];
   assign back_prod  = 32'(s1_quot_ff) * 32'(MEM_WORDS);
   assign s2_prod_in = back_prod[15:0];

   assign rem_raw = {1'b0, s2_item_ff.address} - {1'b0, s2_prod_ff};
   assign rem_fix = (rem_raw >= WORDS) ? (rem_raw - WORDS) : rem_raw;

   always_comb begin
      s1_item_in.cmd       = req_chan.cmd;
      s1_item_in.src_a     = req_chan.src_a;
      s1_item_in.src_b     = req_chan.src_b;
      s1_item_in.dest      = req_chan.dest;
      s1_item_in.immediate = req_chan.immediate;
      s1_item_in.address   = req_chan.address;
      s1_item_in.mem_idx   = '0;
   end

   always_comb begin
      push_item         = s2_item_ff;
      push_item.mem_idx = rem_fix[15:0];
   end

   assign push_valid  = s2_valid_ff;
   assign s1_valid_in = s1_take ? accept : s1_valid_ff;
   assign s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_item_ff <= s1_item_in;
         s1_quot_ff <= s1_quot_in;
      end
      if (s2_take) begin
         s2_item_ff <= s1_item_ff;
         s2_prod_ff <= s2_prod_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/cie_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cie_queue
// Two-entry instruction queue between front end and back end.
// ----------------------------------------------------------------------------
module cie_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  cie_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output cie_pkg::item_type pop_item,
   input  logic              pop_ready
);

   localparam logic [1:0] FULL_COUNT = 2'd2;

   cie_pkg::item_type slots_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   assign wr_ptr_in = push_fire ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop_fire ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 2'd1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/cie_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cie_back
// Operand read with bypass, execute, architectural state and result register.
// Also runs the data memory clear sweep after reset.
// ----------------------------------------------------------------------------
module cie_back #(
   parameter int NUM_REGS  = 8,
   parameter int MEM_WORDS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  cie_pkg::item_type pop_item,
   output logic              pop_ready,
   output logic              clearing,
   cie_rsp_if.source         rsp_chan
);

   localparam int IDX_W  = $clog2(NUM_REGS);
   localparam int MIDX_W = $clog2(MEM_WORDS);

   function automatic logic reg_ok(input logic [2:0] sel);
      return 32'(sel) < NUM_REGS;
   endfunction

   function automatic logic [IDX_W-1:0] reg_idx(input logic [2:0] sel);
      return IDX_W'(sel);
   endfunction

   // architectural state; the register file is kept twice for read ports
   logic [31:0] regs_ab_ff [NUM_REGS];
   logic [31:0] regs_d_ff  [NUM_REGS];
   logic [15:0] mem_ff     [MEM_WORDS];
   logic [15:0] pc_ff, pc_in;
   logic [31:0] xfer_ff, xfer_in;
   logic [15:0] link_ff;

   logic              clr_busy_ff;
   logic [MIDX_W-1:0] clr_idx_ff;

   // execute stage
   logic              ex_valid_ff, ex_valid_in;
   cie_pkg::item_type ex_item_ff;
   logic [31:0]       opa_ff, opa_in;
   logic [31:0]       opb_ff, opb_in;
   logic [31:0]       opd_ff, opd_in;
   logic [15:0]       memrd_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff;
   logic [15:0] rsp_pc_ff;

   logic              ex_fire, pop_fire;
   logic [31:0]       value;
   logic              reg_we, mem_op, link_we;
   logic [15:0]       pc_plus2;
   logic [31:0]       imm_ext;
   logic [4:0]        shamt;
   logic [63:0]       rot_wide;
   logic              rf_we;
   logic [IDX_W-1:0]  rf_widx;
   logic              mem_we;
   logic [MIDX_W-1:0] mem_waddr, pop_midx;
   logic [15:0]       mem_wdata;
   logic              fwd_a, fwd_b, fwd_d, fwd_m;

   assign clearing = clr_busy_ff;
   assign ex_fire  = ex_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign pop_ready = !ex_valid_ff || ex_fire;
   assign pop_fire  = pop_valid && pop_ready;

   assign pc_plus2 = pc_ff + cie_pkg::PC_STEP;
   assign imm_ext  = {{16{ex_item_ff.immediate[15]}}, ex_item_ff.immediate};
   assign shamt    = opb_ff[4:0];
   assign rot_wide = {opa_ff, opa_ff} << shamt;

   always_comb begin
      value   = '0;
      reg_we  = 1'b0;
      mem_op  = 1'b0;
      link_we = 1'b0;
      pc_in   = pc_plus2;
      xfer_in = xfer_ff;
      case (cie_pkg::op_type'(ex_item_ff.cmd))
         cie_pkg::OP_ADD: begin
            value  = opa_ff + opb_ff;
            reg_we = 1'b1;
         end
         cie_pkg::OP_ADDI: begin
            value  = opb_ff + imm_ext;
            reg_we = 1'b1;
         end
         cie_pkg::OP_OR: begin
            value  = opa_ff | opb_ff;
            reg_we = 1'b1;
         end
         cie_pkg::OP_AND: begin
            value  = opa_ff & opb_ff;
            reg_we = 1'b1;
         end
         cie_pkg::OP_XOR: begin
            value  = opa_ff ^ opb_ff;
            reg_we = 1'b1;
         end
         cie_pkg::OP_NOR: begin
            value  = ~(opa_ff | opb_ff);
            reg_we = 1'b1;
         end
         cie_pkg::OP_SLL: begin
            value  = opa_ff << shamt;
            reg_we = 1'b1;
         end
         cie_pkg::OP_ROT: begin
            value  = rot_wide[63:32];
            reg_we = 1'b1;
         end
         cie_pkg::OP_BNE: begin
            pc_in = (opa_ff != opb_ff) ? (pc_ff + opd_ff[15:0]) : pc_plus2;
            value = {16'd0, pc_in};
         end
         cie_pkg::OP_LDL: begin
            xfer_in = {16'd0, memrd_ff};
            value   = xfer_in;
         end
         cie_pkg::OP_LDH: begin
            xfer_in = {memrd_ff, 16'd0};
            value   = xfer_in;
         end
         cie_pkg::OP_STL: begin
            xfer_in = xfer_ff & cie_pkg::STL_MASK;
            mem_op  = 1'b1;
            value   = {16'd0, xfer_in[15:0]};
         end
         cie_pkg::OP_STH: begin
            xfer_in = {16'd0, xfer_ff[31:16]};
            mem_op  = 1'b1;
            value   = {16'd0, xfer_in[15:0]};
         end
         cie_pkg::OP_JMP: begin
            pc_in = ex_item_ff.address;
            value = {16'd0, pc_in};
         end
         cie_pkg::OP_JAL: begin
            link_we = 1'b1;
            pc_in   = ex_item_ff.address;
            value   = {16'd0, pc_in};
         end
         cie_pkg::OP_JR: begin
            pc_in = opa_ff[15:0];
            value = {16'd0, pc_in};
         end
         cie_pkg::OP_JALR: begin
            link_we = 1'b1;
            pc_in   = opa_ff[15:0];
            value   = {16'd0, pc_in};
         end
         cie_pkg::OP_NOP: begin
            value = '0;
         end
         default: begin
            value = '0;
         end
      endcase
   end

   // writeback; out-of-range destinations are dropped
   assign rf_we   = ex_fire && reg_we && reg_ok(ex_item_ff.dest);
   assign rf_widx = reg_idx(ex_item_ff.dest);

   assign mem_we    = clr_busy_ff || (ex_fire && mem_op);
   assign mem_waddr = clr_busy_ff ? clr_idx_ff : ex_item_ff.mem_idx[MIDX_W-1:0];
   assign mem_wdata = clr_busy_ff ? 16'd0 : xfer_in[15:0];
   assign pop_midx  = pop_item.mem_idx[MIDX_W-1:0];

   // bypass the write retiring on the same edge the next beat reads
   assign fwd_a = rf_we && (ex_item_ff.dest == pop_item.src_a);
   assign fwd_b = rf_we && (ex_item_ff.dest == pop_item.src_b);
   assign fwd_d = rf_we && (ex_item_ff.dest == pop_item.dest);
   assign fwd_m = mem_we && (mem_waddr == pop_midx);

   always_comb begin
      opa_in = '0;
      opb_in = '0;
      opd_in = '0;
      if (reg_ok(pop_item.src_a)) begin
         opa_in = fwd_a ? value : regs_ab_ff[reg_idx(pop_item.src_a)];
      end
      if (reg_ok(pop_item.src_b)) begin
         opb_in = fwd_b ? value : regs_ab_ff[reg_idx(pop_item.src_b)];
      end
      if (reg_ok(pop_item.dest)) begin
         opd_in = fwd_d ? value : regs_d_ff[reg_idx(pop_item.dest)];
      end
   end

   assign ex_valid_in  = pop_ready ? pop_valid : ex_valid_ff;
   assign rsp_valid_in = ex_fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         xfer_ff      <= '0;
         link_ff      <= '0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ex_fire) begin
            pc_ff   <= pc_in;
            xfer_ff <= xfer_in;
            if (link_we) begin
               link_ff <= pc_plus2;
            end
         end
         if (clr_busy_ff) begin
            if (clr_idx_ff == MIDX_W'(MEM_WORDS - 1)) begin
               clr_busy_ff <= 1'b0;
            end else begin
               clr_idx_ff <= clr_idx_ff + MIDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ab_ff[i] <= '0;
            regs_d_ff[i]  <= '0;
         end
      end else if (rf_we) begin
         regs_ab_ff[rf_widx] <= value;
         regs_d_ff[rf_widx]  <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         ex_item_ff <= pop_item;
         opa_ff     <= opa_in;
         opb_ff     <= opb_in;
         opd_ff     <= opd_in;
         memrd_ff   <= fwd_m ? mem_wdata : mem_ff[pop_midx];
      end
      if (ex_fire) begin
         rsp_value_ff <= value;
         rsp_pc_ff    <= pc_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.value   = rsp_value_ff;
   assign rsp_chan.next_pc = rsp_pc_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/cie_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cie_checker
// Port-level checks on the execute block, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cie_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic [15:0] rsp_next_pc
);

   // a stalled result beat keeps its payload until taken
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_value) && $stable(rsp_next_pc);
   endproperty

   // the memory sweep starts right after reset, so no beat is taken
   `ASSERT_CLK(a_reset_blocks_req, clock, reset |=> !req_ready, "req ready after reset")

   `ASSERT_CLK(a_reset_drops_rsp, clock, reset |=> !rsp_valid, "rsp valid after reset")

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, p_rsp_hold, "stalled rsp beat changed")

endmodule

bind cpu_instruction_execute cie_checker u_cie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.value),
   .rsp_next_pc(rsp_chan.next_pc)
);
`default_nettype wire
